// File: rtl/core/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 5;
    localparam int OUT_W   = 40;

    typedef enum logic
    {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed
    {
        logic   push;
        logic   pop;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occ,
    input  wire entry_t     left_entry,
    input  wire logic       left_yield,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output entry_t          next_entry,
    output logic            yield
);

    entry_t entry_reg;
    entry_t entry_next;

    // this cell gives way to the new entry (free, or holds an equal or larger priority)
    assign yield = !occ || (entry_reg.prio >= ctrl.new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (left_yield)
            begin
                entry_next = left_entry;
            end
            else if (yield)
            begin
                entry_next = ctrl.new_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry      = entry_reg;
    assign next_entry = entry_next;

endmodule

`default_nettype wire

// File: rtl/core/sorted_priority_queue.sv
`default_nettype none

// Channel  Direction  Payload
// s_*      in         tuser: cmd; tdata: item_priority[15:0], item_tag[31:16]
// m_*      out        tdata: is_empty, front_priority, front_tag, entry_count, status
//
// One request per cycle while s_tready is high: every cell shifts, loads or holds together,
// and the result is registered, valid in the cycle after the request is accepted.
// s_tready is high while the result register is empty or being taken.
// Reset clears the entry count and the result valid; cell contents stay unknown.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,  // item_priority, item_tag
    input  wire logic              s_tuser,  // cmd
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata   // is_empty, front_priority, front_tag,
                                             // entry_count, status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [OUT_W-1:0] m_tdata_next;

    logic       accept;
    logic       is_full;
    logic       is_none;
    cmd_t       cmd;
    status_t    status;
    cell_ctrl_t ctrl;

    entry_t cell_entry [QUEUE_DEPTH];
    entry_t cell_next  [QUEUE_DEPTH];
    logic   cell_yield [QUEUE_DEPTH];
    logic   cell_occ   [QUEUE_DEPTH];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign is_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign is_none  = (count_reg == '0);

    always_comb
    begin
        ctrl.push           = accept && (cmd == CMD_PUSH) && !is_full;
        ctrl.pop            = accept && (cmd == CMD_POP) && !is_none;
        ctrl.new_entry.prio = s_tdata[15:0];
        ctrl.new_entry.tag  = s_tdata[31:16];
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_y;

            assign cell_occ[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_e = cell_entry[gi];
                assign left_y = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_y = cell_yield[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (cell_occ[gi]),
                .left_entry  (left_e),
                .left_yield  (left_y),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .next_entry  (cell_next[gi]),
                .yield       (cell_yield[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        status     = ST_OK;
        if (ctrl.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd == CMD_PUSH && is_full)
        begin
            status = ST_PUSH_FULL;
        end
        else if (cmd == CMD_POP && is_none)
        begin
            status = ST_POP_EMPTY;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept)
        begin
            m_tvalid_next = 1'b1;
            if (count_next == '0)
            begin
                m_tdata_next[32:0] = {32'd0, 1'b1};
            end
            else
            begin
                m_tdata_next[32:0] = {cell_next[0].tag, cell_next[0].prio, 1'b0};
            end
            m_tdata_next[37:33] = COUNT_W'(count_next);
            m_tdata_next[39:38] = status;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow count");

    a_front_order: assert property (@(posedge clk) disable iff (!rst_n)
        cell_occ[1] |-> cell_entry[0].prio <= cell_entry[1].prio)
        else $error("front cells out of order");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_POP && is_none) |=> m_tvalid && m_tdata[0])
        else $error("pop on empty lost empty flag");

endmodule

`default_nettype wire
